>>> hdl/cotangent_edge_weight_macros.svh
// assertion helpers for the checker module
`ifndef COTANGENT_EDGE_WEIGHT_MACROS_SVH
`define COTANGENT_EDGE_WEIGHT_MACROS_SVH

// implication in the same cycle
`define CEW_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// implication after a fixed number of cycles
`define CEW_ASSERT_DELAY(lbl, ant, n, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> ##(n) (con)) \
		else $error(msg);

// condition that must never hold
`define CEW_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

>>> hdl/cew_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cew_pkg;

	localparam int COORD_WIDTH_DEF  = 24;
	localparam int WEIGHT_WIDTH_DEF = 32;

	// working vector component and norm widths
	localparam int VW     = 25;
	localparam int NW     = 2 * VW;
	localparam int HW     = NW / 2;
	localparam int RAD_W  = 2 * NW;
	localparam int RT1_W  = NW;
	localparam int CQ_W   = 31;
	localparam int X_W    = 2 * CQ_W - 1;
	localparam int RT2_W  = CQ_W;
	localparam int DQ_W   = 2 * CQ_W - 1;

	localparam logic [CQ_W-1:0]   ONE_Q30 = CQ_W'(1) << 30;
	localparam logic [2*CQ_W-1:0] ONE_Q60 = (2 * CQ_W)'(1) << 60;

	// stage counts
	localparam int PRE_STAGES    = 4;
	localparam int MID_STAGES    = 3;
	localparam int ANGLE_LATENCY = PRE_STAGES + RT1_W + CQ_W + MID_STAGES + RT2_W + DQ_W;
	localparam int LATENCY       = 1 + ANGLE_LATENCY + 2;

	typedef logic signed [VW-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
	} vec_t;

	typedef struct packed {
		logic            neg;
		logic            inf;
		logic [DQ_W-1:0] mag;
	} cot_t;

endpackage

`default_nettype wire

>>> hdl/cew_angle.sv
`timescale 1ns / 1ps
`default_nettype none

module cew_angle (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  cew_pkg::vec_t u,
	input  cew_pkg::vec_t v,
	output logic          out_valid,
	output cew_pkg::cot_t cot
);
	import cew_pkg::*;

	localparam int RM1_W = RT1_W + 1;
	localparam int RM2_W = RT2_W + 1;
	localparam int SR2_W = 2 * RT2_W;

	// products
	logic                   vld_s1;
	logic signed [NW-1:0]   uv_s1 [3];
	logic signed [NW-1:0]   uu_s1 [3];
	logic signed [NW-1:0]   vv_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		uv_s1[0] <= u.x * v.x;
		uv_s1[1] <= u.y * v.y;
		uv_s1[2] <= u.z * v.z;
		uu_s1[0] <= u.x * u.x;
		uu_s1[1] <= u.y * u.y;
		uu_s1[2] <= u.z * u.z;
		vv_s1[0] <= v.x * v.x;
		vv_s1[1] <= v.y * v.y;
		vv_s1[2] <= v.z * v.z;
	end

	// sums
	logic signed [NW+1:0] dot_sum, nu_sum, nv_sum, dot_abs;
	logic                 vld_s2, dneg_s2, zero_s2;
	logic [NW-1:0]        dmag_s2, nu_s2, nv_s2;

	always_comb begin
		dot_sum = (NW+2)'(uv_s1[0]) + (NW+2)'(uv_s1[1]) + (NW+2)'(uv_s1[2]);
		nu_sum  = (NW+2)'(uu_s1[0]) + (NW+2)'(uu_s1[1]) + (NW+2)'(uu_s1[2]);
		nv_sum  = (NW+2)'(vv_s1[0]) + (NW+2)'(vv_s1[1]) + (NW+2)'(vv_s1[2]);
		dot_abs = dot_sum[NW+1] ? -dot_sum : dot_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dneg_s2 <= dot_sum[NW+1];
		dmag_s2 <= dot_abs[NW-1:0];
		nu_s2   <= nu_sum[NW-1:0];
		nv_s2   <= nv_sum[NW-1:0];
		zero_s2 <= (nu_sum == '0) || (nv_sum == '0);
	end

	// partial products of nu * nv
	logic          vld_s3, dneg_s3, zero_s3;
	logic [NW-1:0] dmag_s3, pp_hh_s3, pp_hl_s3, pp_lh_s3, pp_ll_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dneg_s3  <= dneg_s2;
		dmag_s3  <= dmag_s2;
		zero_s3  <= zero_s2;
		pp_hh_s3 <= nu_s2[NW-1:HW] * nv_s2[NW-1:HW];
		pp_hl_s3 <= nu_s2[NW-1:HW] * nv_s2[HW-1:0];
		pp_lh_s3 <= nu_s2[HW-1:0] * nv_s2[NW-1:HW];
		pp_ll_s3 <= nu_s2[HW-1:0] * nv_s2[HW-1:0];
	end

	logic             vld_s4, dneg_s4, zero_s4;
	logic [NW-1:0]    dmag_s4;
	logic [RAD_W-1:0] rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dneg_s4 <= dneg_s3;
		dmag_s4 <= dmag_s3;
		zero_s4 <= zero_s3;
		rad_s4  <= (RAD_W'(pp_hh_s3) << NW)
			+ ((RAD_W'(pp_hl_s3) + RAD_W'(pp_lh_s3)) << HW)
			+ RAD_W'(pp_ll_s3);
	end

	// square root of nu * nv, one root bit per stage
	logic             sq1_vld_s  [RT1_W];
	logic [RM1_W-1:0] sq1_rem_s  [RT1_W];
	logic [RT1_W-1:0] sq1_root_s [RT1_W];
	logic [RAD_W-1:0] sq1_rad_s  [RT1_W];
	logic             sq1_neg_s  [RT1_W];
	logic             sq1_zero_s [RT1_W];
	logic [NW-1:0]    sq1_dmag_s [RT1_W];

	for (genvar i = 0; i < RT1_W; i++) begin : g_sq1
		logic             vld_in, neg_in, zero_in, ge;
		logic [RM1_W-1:0] rem_in;
		logic [RT1_W-1:0] root_in;
		logic [RAD_W-1:0] rad_in;
		logic [NW-1:0]    dmag_in;
		logic [RT1_W+2:0] rem_ext, trial;

		if (i == 0) begin : g_first
			assign vld_in  = vld_s4;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s4;
			assign neg_in  = dneg_s4;
			assign zero_in = zero_s4;
			assign dmag_in = dmag_s4;
		end else begin : g_next
			assign vld_in  = sq1_vld_s[i-1];
			assign rem_in  = sq1_rem_s[i-1];
			assign root_in = sq1_root_s[i-1];
			assign rad_in  = sq1_rad_s[i-1];
			assign neg_in  = sq1_neg_s[i-1];
			assign zero_in = sq1_zero_s[i-1];
			assign dmag_in = sq1_dmag_s[i-1];
		end

		assign rem_ext = {rem_in, rad_in[RAD_W-1-2*i -: 2]};
		assign trial   = {1'b0, root_in, 2'b01};
		assign ge      = rem_ext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq1_vld_s[i] <= 1'b0;
			end else begin
				sq1_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sq1_rem_s[i]  <= ge ? RM1_W'(rem_ext - trial) : rem_ext[RM1_W-1:0];
			sq1_root_s[i] <= {root_in[RT1_W-2:0], ge};
			sq1_rad_s[i]  <= rad_in;
			sq1_neg_s[i]  <= neg_in;
			sq1_zero_s[i] <= zero_in;
			sq1_dmag_s[i] <= dmag_in;
		end
	end

	// cosine magnitude |dot| * 2^30 / r, one quotient bit per stage
	logic             dv1_vld_s  [CQ_W];
	logic [RM1_W-1:0] dv1_rem_s  [CQ_W];
	logic [CQ_W-1:0]  dv1_q_s    [CQ_W];
	logic [RT1_W-1:0] dv1_r_s    [CQ_W];
	logic             dv1_neg_s  [CQ_W];
	logic             dv1_zero_s [CQ_W];

	for (genvar j = 0; j < CQ_W; j++) begin : g_dv1
		logic             vld_in, neg_in, zero_in, ge;
		logic [RM1_W-1:0] rem_in, rn, rdiv;
		logic [CQ_W-1:0]  q_in;
		logic [RT1_W-1:0] r_in;

		if (j == 0) begin : g_first
			assign vld_in  = sq1_vld_s[RT1_W-1];
			assign rem_in  = {1'b0, sq1_dmag_s[RT1_W-1]};
			assign q_in    = '0;
			assign r_in    = sq1_root_s[RT1_W-1];
			assign neg_in  = sq1_neg_s[RT1_W-1];
			assign zero_in = sq1_zero_s[RT1_W-1];
			assign rn      = rem_in;
		end else begin : g_next
			assign vld_in  = dv1_vld_s[j-1];
			assign rem_in  = dv1_rem_s[j-1];
			assign q_in    = dv1_q_s[j-1];
			assign r_in    = dv1_r_s[j-1];
			assign neg_in  = dv1_neg_s[j-1];
			assign zero_in = dv1_zero_s[j-1];
			assign rn      = {rem_in[RM1_W-2:0], 1'b0};
		end

		assign rdiv = {1'b0, r_in};
		assign ge   = rn >= rdiv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv1_vld_s[j] <= 1'b0;
			end else begin
				dv1_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv1_rem_s[j]  <= ge ? rn - rdiv : rn;
			dv1_q_s[j]    <= {q_in[CQ_W-2:0], ge};
			dv1_r_s[j]    <= r_in;
			dv1_neg_s[j]  <= neg_in;
			dv1_zero_s[j] <= zero_in;
		end
	end

	// clamp, square, 1 - c^2
	logic              vld_c1, vld_c2, vld_c3;
	logic              cneg_c1, cneg_c2, cneg_c3;
	logic [CQ_W-1:0]   cmag_c1, cmag_c2, cmag_c3;
	logic [2*CQ_W-1:0] msq_c2, x_full;
	logic [X_W-1:0]    x_c3;
	logic [CQ_W-1:0]   q_last;

	assign q_last = dv1_q_s[CQ_W-1];
	assign x_full = ONE_Q60 - msq_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
			vld_c3 <= 1'b0;
		end else begin
			vld_c1 <= dv1_vld_s[CQ_W-1];
			vld_c2 <= vld_c1;
			vld_c3 <= vld_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (dv1_zero_s[CQ_W-1]) begin
			cmag_c1 <= '0;
		end else begin
			cmag_c1 <= (q_last > ONE_Q30) ? ONE_Q30 : q_last;
		end
		cneg_c1 <= dv1_neg_s[CQ_W-1] && !dv1_zero_s[CQ_W-1] && (q_last != '0);
		msq_c2  <= cmag_c1 * cmag_c1;
		cmag_c2 <= cmag_c1;
		cneg_c2 <= cneg_c1;
		x_c3    <= x_full[X_W-1:0];
		cmag_c3 <= cmag_c2;
		cneg_c3 <= cneg_c2;
	end

	// sine by square root
	logic             sq2_vld_s  [RT2_W];
	logic [RM2_W-1:0] sq2_rem_s  [RT2_W];
	logic [RT2_W-1:0] sq2_root_s [RT2_W];
	logic [SR2_W-1:0] sq2_rad_s  [RT2_W];
	logic [CQ_W-1:0]  sq2_mag_s  [RT2_W];
	logic             sq2_neg_s  [RT2_W];

	for (genvar i = 0; i < RT2_W; i++) begin : g_sq2
		logic             vld_in, neg_in, ge;
		logic [RM2_W-1:0] rem_in;
		logic [RT2_W-1:0] root_in;
		logic [SR2_W-1:0] rad_in;
		logic [CQ_W-1:0]  mag_in;
		logic [RT2_W+2:0] rem_ext, trial;

		if (i == 0) begin : g_first
			assign vld_in  = vld_c3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = {1'b0, x_c3};
			assign mag_in  = cmag_c3;
			assign neg_in  = cneg_c3;
		end else begin : g_next
			assign vld_in  = sq2_vld_s[i-1];
			assign rem_in  = sq2_rem_s[i-1];
			assign root_in = sq2_root_s[i-1];
			assign rad_in  = sq2_rad_s[i-1];
			assign mag_in  = sq2_mag_s[i-1];
			assign neg_in  = sq2_neg_s[i-1];
		end

		assign rem_ext = {rem_in, rad_in[SR2_W-1-2*i -: 2]};
		assign trial   = {1'b0, root_in, 2'b01};
		assign ge      = rem_ext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq2_vld_s[i] <= 1'b0;
			end else begin
				sq2_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sq2_rem_s[i]  <= ge ? RM2_W'(rem_ext - trial) : rem_ext[RM2_W-1:0];
			sq2_root_s[i] <= {root_in[RT2_W-2:0], ge};
			sq2_rad_s[i]  <= rad_in;
			sq2_mag_s[i]  <= mag_in;
			sq2_neg_s[i]  <= neg_in;
		end
	end

	// cotangent |c| * 2^30 / s
	logic             dv2_vld_s [DQ_W];
	logic [RT2_W-1:0] dv2_rem_s [DQ_W];
	logic [DQ_W-1:0]  dv2_q_s   [DQ_W];
	logic [RT2_W-1:0] dv2_s_s   [DQ_W];
	logic [CQ_W-1:0]  dv2_mag_s [DQ_W];
	logic             dv2_neg_s [DQ_W];

	for (genvar j = 0; j < DQ_W; j++) begin : g_dv2
		logic             vld_in, neg_in, ge;
		logic [RT2_W-1:0] rem_in, s_in;
		logic [DQ_W-1:0]  q_in, dvd;
		logic [CQ_W-1:0]  mag_in;
		logic [RT2_W:0]   rn, sdiv, rsub;

		if (j == 0) begin : g_first
			assign vld_in = sq2_vld_s[RT2_W-1];
			assign rem_in = '0;
			assign q_in   = '0;
			assign s_in   = sq2_root_s[RT2_W-1];
			assign mag_in = sq2_mag_s[RT2_W-1];
			assign neg_in = sq2_neg_s[RT2_W-1];
		end else begin : g_next
			assign vld_in = dv2_vld_s[j-1];
			assign rem_in = dv2_rem_s[j-1];
			assign q_in   = dv2_q_s[j-1];
			assign s_in   = dv2_s_s[j-1];
			assign mag_in = dv2_mag_s[j-1];
			assign neg_in = dv2_neg_s[j-1];
		end

		assign dvd  = {mag_in, {(DQ_W-CQ_W){1'b0}}};
		assign rn   = {rem_in, dvd[DQ_W-1-j]};
		assign sdiv = {1'b0, s_in};
		assign rsub = rn - sdiv;
		assign ge   = rn >= sdiv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv2_vld_s[j] <= 1'b0;
			end else begin
				dv2_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv2_rem_s[j] <= ge ? rsub[RT2_W-1:0] : rn[RT2_W-1:0];
			dv2_q_s[j]   <= {q_in[DQ_W-2:0], ge};
			dv2_s_s[j]   <= s_in;
			dv2_mag_s[j] <= mag_in;
			dv2_neg_s[j] <= neg_in;
		end
	end

	assign out_valid = dv2_vld_s[DQ_W-1];
	assign cot.neg   = dv2_neg_s[DQ_W-1];
	assign cot.inf   = (dv2_s_s[DQ_W-1] == '0);
	assign cot.mag   = dv2_q_s[DQ_W-1];

endmodule

`default_nettype wire

>>> hdl/cotangent_edge_weight.sv
`timescale 1ns / 1ps
`default_nettype none

// cotangent edge weight
//
// input: raise start with the twelve vertex coordinates p0..p3 (x, y, z)
// of an interior edge; a transaction is taken at every clock edge with start
// high and busy low. busy stays low, so one edge can enter every cycle.
// output: done is high for one cycle with edge_weight (signed Q16.15,
// half the sum of the two cotangents) and weight_saturated.
// throughput one result per cycle. a transaction passes through the
// bit-per-stage pipelines: the 50-stage square root of |u|^2*|v|^2, the
// 31-stage cosine divide, the 31-stage sine root and the 61-stage
// cotangent divide, plus input, product, clamp and output stages.
// results appear in input order, one per transaction.
// reset clears all valid bits; transactions in flight are dropped.
// the receiver cannot stall: every done pulse must be taken as it comes.

module cotangent_edge_weight #(
	parameter int COORD_WIDTH  = cew_pkg::COORD_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = cew_pkg::WEIGHT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [COORD_WIDTH-1:0]  p0_x,
	input  logic signed [COORD_WIDTH-1:0]  p0_y,
	input  logic signed [COORD_WIDTH-1:0]  p0_z,
	input  logic signed [COORD_WIDTH-1:0]  p1_x,
	input  logic signed [COORD_WIDTH-1:0]  p1_y,
	input  logic signed [COORD_WIDTH-1:0]  p1_z,
	input  logic signed [COORD_WIDTH-1:0]  p2_x,
	input  logic signed [COORD_WIDTH-1:0]  p2_y,
	input  logic signed [COORD_WIDTH-1:0]  p2_z,
	input  logic signed [COORD_WIDTH-1:0]  p3_x,
	input  logic signed [COORD_WIDTH-1:0]  p3_y,
	input  logic signed [COORD_WIDTH-1:0]  p3_z,
	output logic                           done,
	output logic signed [WEIGHT_WIDTH-1:0] edge_weight,
	output logic                           weight_saturated
);
	import cew_pkg::*;

	localparam int DW     = COORD_WIDTH + 1;
	localparam int WSHIFT = (COORD_WIDTH > VW - 1) ? COORD_WIDTH - (VW - 1) : 0;
	localparam int SW     = DQ_W + 2;
	localparam logic signed [SW-1:0] WMAX = (SW'(1) << (WEIGHT_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] WMIN = -WMAX - SW'(1);
	localparam logic signed [SW-1:0] HALF = SW'(32768);

	function automatic comp_t diff(input logic signed [COORD_WIDTH-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] ds;
		d  = DW'(a) - DW'(b);
		ds = d >>> WSHIFT;
		return comp_t'(ds);
	endfunction

	assign busy = 1'b0;

	// edge vectors
	logic vld_d1;
	vec_t ea_d1, eb_d1, fa_d1, fb_d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d1 <= 1'b0;
		end else begin
			vld_d1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ea_d1.x <= diff(p1_x, p0_x);
		ea_d1.y <= diff(p1_y, p0_y);
		ea_d1.z <= diff(p1_z, p0_z);
		eb_d1.x <= diff(p2_x, p0_x);
		eb_d1.y <= diff(p2_y, p0_y);
		eb_d1.z <= diff(p2_z, p0_z);
		fa_d1.x <= diff(p0_x, p1_x);
		fa_d1.y <= diff(p0_y, p1_y);
		fa_d1.z <= diff(p0_z, p1_z);
		fb_d1.x <= diff(p3_x, p1_x);
		fb_d1.y <= diff(p3_y, p1_y);
		fb_d1.z <= diff(p3_z, p1_z);
	end

	logic vld_a, vld_b;
	cot_t cot_a, cot_b;

	cew_angle u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_d1),
		.u         (ea_d1),
		.v         (eb_d1),
		.out_valid (vld_a),
		.cot       (cot_a)
	);

	cew_angle u_beta (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_d1),
		.u         (fa_d1),
		.v         (fb_d1),
		.out_valid (vld_b),
		.cot       (cot_b)
	);

	// sum and infinite terms
	logic signed [SW-1:0] tmag_a, tmag_b, ta, tb;
	logic                 a_pos, a_ng, b_pos, b_ng;
	logic                 vld_f1, inf_f1, pos_f1, ng_f1;
	logic signed [SW-1:0] sum_f1;

	always_comb begin
		tmag_a = SW'(cot_a.mag);
		tmag_b = SW'(cot_b.mag);
		ta     = cot_a.neg ? -tmag_a : tmag_a;
		tb     = cot_b.neg ? -tmag_b : tmag_b;
		a_pos  = cot_a.inf && !cot_a.neg;
		a_ng   = cot_a.inf && cot_a.neg;
		b_pos  = cot_b.inf && !cot_b.neg;
		b_ng   = cot_b.inf && cot_b.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
		end else begin
			vld_f1 <= vld_a && vld_b;
		end
	end

	always_ff @(posedge clk) begin
		inf_f1 <= cot_a.inf || cot_b.inf;
		pos_f1 <= (a_pos && !b_ng) || (b_pos && !a_ng);
		ng_f1  <= (a_ng && !b_pos) || (b_ng && !a_pos);
		sum_f1 <= ta + tb;
	end

	// round, halve and saturate
	logic signed [SW-1:0] rnd, wq, wsel;
	logic                 sat;

	always_comb begin
		rnd = sum_f1 + HALF;
		wq  = rnd >>> 16;
		priority if (inf_f1) begin
			sat  = 1'b1;
			wsel = pos_f1 ? WMAX : (ng_f1 ? WMIN : '0);
		end else if (wq > WMAX) begin
			sat  = 1'b1;
			wsel = WMAX;
		end else if (wq < WMIN) begin
			sat  = 1'b1;
			wsel = WMIN;
		end else begin
			sat  = 1'b0;
			wsel = wq;
		end
	end

	logic                           done_q, sat_q;
	logic signed [WEIGHT_WIDTH-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_f1;
		end
	end

	always_ff @(posedge clk) begin
		weight_q <= wsel[WEIGHT_WIDTH-1:0];
		sat_q    <= sat;
	end

	assign done             = done_q;
	assign edge_weight      = weight_q;
	assign weight_saturated = sat_q;

endmodule

`default_nettype wire

>>> hdl/cew_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cotangent_edge_weight_macros.svh"

module cew_checker #(
	parameter int WEIGHT_WIDTH = cew_pkg::WEIGHT_WIDTH_DEF,
	parameter int LATENCY      = cew_pkg::LATENCY
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic signed [WEIGHT_WIDTH-1:0] edge_weight,
	input logic                           weight_saturated
);
	localparam logic [WEIGHT_WIDTH-1:0] WMAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
	localparam logic [WEIGHT_WIDTH-1:0] WMIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

	`CEW_ASSERT_NEVER(a_never_busy, busy, "busy raised on a stall-free pipeline")
	`CEW_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done, "result missing after latency")
	`CEW_ASSERT_IMP(a_done_cause, done, $past(start && !busy, LATENCY), "result without transaction")
	`CEW_ASSERT_IMP(a_sat_value, done && weight_saturated,
		edge_weight == WMAX || edge_weight == WMIN || edge_weight == '0,
		"saturated weight not at a bound or zero")

endmodule

bind cotangent_edge_weight cew_checker #(
	.WEIGHT_WIDTH (WEIGHT_WIDTH)
) u_cew_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.edge_weight      (edge_weight),
	.weight_saturated (weight_saturated)
);

`default_nettype wire
